@@ hdl/stick_direction_auto_repeat_assert.svh @@
// Assertion macros used by the checker file of the stick auto repeat block.
`ifndef STICK_DIRECTION_AUTO_REPEAT_ASSERT_SVH
`define STICK_DIRECTION_AUTO_REPEAT_ASSERT_SVH

// Same-cycle implication, disabled while reset is high.
`define SDAR_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while reset is high.
`define SDAR_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ hdl/sdar_pkg.sv @@
// ----------------------------------------------------------------------------
// sdar_pkg
// Types, widths and codes of the stick direction auto repeat block.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package sdar_pkg;

  localparam int AXIS_W      = 16;
  localparam int DT_W        = 20;
  localparam int TIMER_W     = 32;
  localparam int DZ_W        = 15;
  localparam int DZSQ_W      = 2 * DZ_W;
  localparam int SQ_W        = 31;
  localparam int MAG_W       = 32;
  localparam int IN_TDATA_W  = 56;
  localparam int OUT_TDATA_W = 8;
  localparam int CFG_IDX_W   = 2;
  localparam int CFG_DATA_W  = 32;

  // Bit positions of the input fields in s_tdata.
  localparam int X_LSB      = 0;
  localparam int Y_LSB      = X_LSB + AXIS_W;
  localparam int DT_LSB     = Y_LSB + AXIS_W;
  localparam int ACTIVE_BIT = DT_LSB + DT_W;

  typedef logic [1:0] dir_t;
  localparam dir_t DIR_UP    = 2'd0;
  localparam dir_t DIR_DOWN  = 2'd1;
  localparam dir_t DIR_LEFT  = 2'd2;
  localparam dir_t DIR_RIGHT = 2'd3;

  typedef logic [CFG_IDX_W-1:0] cfg_idx_t;
  localparam cfg_idx_t REG_DEAD_ZONE       = 2'd0;
  localparam cfg_idx_t REG_REPEAT_DELAY    = 2'd1;
  localparam cfg_idx_t REG_REPEAT_INTERVAL = 2'd2;

  // Reset values; the dead zone is kept squared (8192 squared).
  localparam logic [DZSQ_W-1:0]  DZ_SQ_RESET         = 30'd67108864;
  localparam logic [TIMER_W-1:0] REPEAT_DELAY_RESET    = 32'd400000;
  localparam logic [TIMER_W-1:0] REPEAT_INTERVAL_RESET = 32'd100000;

  // One tick after the squaring stage.
  typedef struct packed {
    logic            active;
    dir_t            dir;
    logic [DT_W-1:0] dt;
    logic [SQ_W-1:0] xs;
    logic [SQ_W-1:0] ys;
  } sq_stage_t;

  // Timer add that sticks at all ones on overflow.
  function automatic logic [TIMER_W-1:0] sat_add(input logic [TIMER_W-1:0] a,
                                                 input logic [DT_W-1:0] b);
    logic [TIMER_W:0] sum;
    sum = {1'b0, a} + {{(TIMER_W + 1 - DT_W){1'b0}}, b};
    return sum[TIMER_W] ? {TIMER_W{1'b1}} : sum[TIMER_W-1:0];
  endfunction

endpackage

@@ hdl/stick_direction_auto_repeat.sv @@
// ----------------------------------------------------------------------------
// stick_direction_auto_repeat
// Turns polled analog stick samples into four-way navigation events with
// typematic repeat.
// ----------------------------------------------------------------------------
// Each transaction on the slave side is one polling tick: two Q1.15 axes, the
// microseconds since the previous tick and an active flag. Every tick yields
// exactly one transaction on the master side carrying nav_valid and nav_dir;
// nav_dir is zero when nav_valid is zero.
// The path has three register stages: input register, squaring register and
// the result register, where the held/timer state is updated. A tick taken
// at the input passes the squaring and result registers before it shows on
// the master side; one tick per cycle is sustained while m_tready stays high;
// the squaring multipliers and the timer update each fill one stage.
// When the receiver stalls, results queue in the stages and s_tready falls
// only once all three are full.
// The config channel (cfg_valid/cfg_ready, cfg_index, cfg_data) is always
// ready; write it only while no tick is in flight. The dead zone is squared
// as it is written.
// Reset (rst, synchronous) empties the pipeline, clears the state and loads
// the register defaults.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module stick_direction_auto_repeat
  import sdar_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   s_tvalid,
  output logic                   s_tready,
  // axis_x [15:0], axis_y [31:16], delta_time [51:32], ui_active [52], zero pad
  input  logic [IN_TDATA_W-1:0]  s_tdata,
  output logic                   m_tvalid,
  input  logic                   m_tready,
  // nav_valid [0], nav_dir [2:1], zero pad
  output logic [OUT_TDATA_W-1:0] m_tdata,
  input  logic                   cfg_valid,
  output logic                   cfg_ready,
  input  logic [CFG_IDX_W-1:0]   cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_data
);

  // Configuration.
  logic [DZSQ_W-1:0]  dead_zone_sq;
  logic [TIMER_W-1:0] repeat_delay;
  logic [TIMER_W-1:0] repeat_interval;
  logic [DZSQ_W-1:0]  dz_prod;

  // Pipeline.
  logic                     in_vld;
  logic signed [AXIS_W-1:0] in_x;
  logic signed [AXIS_W-1:0] in_y;
  logic [DT_W-1:0]          in_dt;
  logic                     in_act;
  logic                     sq_vld;
  sq_stage_t                sq;
  sq_stage_t                sq_next;
  logic                     out_vld;
  logic                     out_nav_valid;
  dir_t                     out_nav_dir;

  logic out_ready;
  logic sq_ready;
  logic out_load;

  // Navigation state.
  logic               held;
  dir_t               last_dir;
  logic [TIMER_W-1:0] hold_time;
  logic [TIMER_W-1:0] repeat_time;
  logic               held_next;
  dir_t               last_dir_next;
  logic [TIMER_W-1:0] hold_time_next;
  logic [TIMER_W-1:0] repeat_time_next;
  logic               nav_valid_next;
  dir_t               nav_dir_next;

  logic signed [2*AXIS_W-1:0] x_prod;
  logic signed [2*AXIS_W-1:0] y_prod;
  logic signed [AXIS_W:0]     x_ext;
  logic signed [AXIS_W:0]     y_ext;
  logic [AXIS_W:0]            ax;
  logic [AXIS_W:0]            ay;
  logic                       x_pos;
  logic                       y_pos;
  logic [MAG_W-1:0]           mag2;
  logic                       outside;
  logic [TIMER_W-1:0]         hold_sum;
  logic [TIMER_W-1:0]         repeat_sum;

  assign cfg_ready = 1'b1;
  assign dz_prod   = DZSQ_W'(cfg_data[DZ_W-1:0]) * DZSQ_W'(cfg_data[DZ_W-1:0]);

  always_ff @(posedge clk) begin
    if (rst) begin
      dead_zone_sq    <= DZ_SQ_RESET;
      repeat_delay    <= REPEAT_DELAY_RESET;
      repeat_interval <= REPEAT_INTERVAL_RESET;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        REG_DEAD_ZONE:       dead_zone_sq    <= dz_prod;
        REG_REPEAT_DELAY:    repeat_delay    <= cfg_data;
        REG_REPEAT_INTERVAL: repeat_interval <= cfg_data;
        default: ;
      endcase
    end
  end

  // Each stage moves on when the one after it is free or moving.
  assign out_ready = !out_vld || m_tready;
  assign sq_ready  = !sq_vld || out_ready;
  assign s_tready  = !in_vld || sq_ready;
  assign out_load  = sq_vld && out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_vld <= 1'b0;
    end else if (s_tready) begin
      in_vld <= s_tvalid;
    end
    if (s_tready && s_tvalid) begin
      in_x   <= s_tdata[X_LSB +: AXIS_W];
      in_y   <= s_tdata[Y_LSB +: AXIS_W];
      in_dt  <= s_tdata[DT_LSB +: DT_W];
      in_act <= s_tdata[ACTIVE_BIT];
    end
  end

  // Squares and direction pick.
  always_comb begin
    x_prod = (2*AXIS_W)'(in_x) * (2*AXIS_W)'(in_x);
    y_prod = (2*AXIS_W)'(in_y) * (2*AXIS_W)'(in_y);
    x_ext  = {in_x[AXIS_W-1], in_x};
    y_ext  = {in_y[AXIS_W-1], in_y};
    ax     = x_ext[AXIS_W] ? $unsigned(-x_ext) : $unsigned(x_ext);
    ay     = y_ext[AXIS_W] ? $unsigned(-y_ext) : $unsigned(y_ext);
    x_pos  = !in_x[AXIS_W-1] && (in_x != '0);
    y_pos  = !in_y[AXIS_W-1] && (in_y != '0);
    sq_next.active = in_act;
    sq_next.dt     = in_dt;
    sq_next.xs     = x_prod[SQ_W-1:0];
    sq_next.ys     = y_prod[SQ_W-1:0];
    if (ax > ay) begin
      sq_next.dir = x_pos ? DIR_RIGHT : DIR_LEFT;
    end else begin
      sq_next.dir = y_pos ? DIR_UP : DIR_DOWN;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      sq_vld <= 1'b0;
    end else if (sq_ready) begin
      sq_vld <= in_vld;
    end
    if (sq_ready && in_vld) begin
      sq <= sq_next;
    end
  end

  // Dead zone test and the typematic state update.
  always_comb begin
    mag2       = MAG_W'(sq.xs) + MAG_W'(sq.ys);
    outside    = mag2 > MAG_W'(dead_zone_sq);
    hold_sum   = sat_add(hold_time, sq.dt);
    repeat_sum = sat_add(repeat_time, sq.dt);

    held_next        = held;
    last_dir_next    = last_dir;
    hold_time_next   = hold_time;
    repeat_time_next = repeat_time;
    nav_valid_next   = 1'b0;
    nav_dir_next     = DIR_UP;

    if (sq.active && outside) begin
      if (!held || sq.dir != last_dir) begin
        held_next        = 1'b1;
        last_dir_next    = sq.dir;
        hold_time_next   = '0;
        repeat_time_next = '0;
        nav_valid_next   = 1'b1;
        nav_dir_next     = sq.dir;
      end else begin
        hold_time_next = hold_sum;
        if (hold_sum > repeat_delay) begin
          if (repeat_sum >= repeat_interval) begin
            repeat_time_next = '0;
            nav_valid_next   = 1'b1;
            nav_dir_next     = sq.dir;
          end else begin
            repeat_time_next = repeat_sum;
          end
        end
      end
    end else if (sq.active) begin
      held_next      = 1'b0;
      hold_time_next = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_vld     <= 1'b0;
      held        <= 1'b0;
      last_dir    <= DIR_UP;
      hold_time   <= '0;
      repeat_time <= '0;
    end else begin
      if (out_ready) begin
        out_vld <= sq_vld;
      end
      if (out_load) begin
        held        <= held_next;
        last_dir    <= last_dir_next;
        hold_time   <= hold_time_next;
        repeat_time <= repeat_time_next;
      end
    end
    if (out_load) begin
      out_nav_valid <= nav_valid_next;
      out_nav_dir   <= nav_dir_next;
    end
  end

  assign m_tvalid = out_vld;
  assign m_tdata  = {{(OUT_TDATA_W - 3){1'b0}}, out_nav_dir, out_nav_valid};

endmodule

@@ hdl/sdar_checker.sv @@
// ----------------------------------------------------------------------------
// sdar_checker
// Port-level checks of the stick direction auto repeat block.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "stick_direction_auto_repeat_assert.svh"

module sdar_checker
  import sdar_pkg::*;
(
  input logic                   clk,
  input logic                   rst,
  input logic                   s_tready,
  input logic                   m_tvalid,
  input logic                   m_tready,
  input logic [OUT_TDATA_W-1:0] m_tdata,
  input logic                   cfg_valid,
  input logic                   cfg_ready
);

  // A stalled result transaction keeps its data.
  `SDAR_ASSERT_NEXT(a_out_hold, clk, rst, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata), "stalled result changed")

  // Without a pending result the pipeline has room for a tick.
  `SDAR_ASSERT_NOW(a_ready_when_empty, clk, rst, !m_tvalid, s_tready, "input refused with empty output")

  // No event means the direction field reads as up.
  `SDAR_ASSERT_NOW(a_dir_zero, clk, rst, m_tvalid && !m_tdata[0], m_tdata[2:1] == DIR_UP, "direction set without event")

  // Register writes never wait.
  `SDAR_ASSERT_NOW(a_cfg_ready, clk, rst, cfg_valid, cfg_ready, "config write refused")

endmodule

bind stick_direction_auto_repeat sdar_checker u_sdar_checker (
  .clk       (clk),
  .rst       (rst),
  .s_tready  (s_tready),
  .m_tvalid  (m_tvalid),
  .m_tready  (m_tready),
  .m_tdata   (m_tdata),
  .cfg_valid (cfg_valid),
  .cfg_ready (cfg_ready)
);

@@ tb/sv/stick_direction_auto_repeat_test.sv @@
// ----------------------------------------------------------------------------
// stick_direction_auto_repeat_test
// Self-checking bench for the stick direction auto repeat block.
// ----------------------------------------------------------------------------
// A table of hand-picked ticks runs first: the dead zone boundary, axis
// extremes, ties between the axes, inactive ticks and the first repeat.
// Then come random held-stick runs, dead zone runs and noise under several
// register settings, the extremes among them. A predictor in the bench
// tracks the held direction and the timers, and every result on the master
// side is compared with it. Both sides of the stream idle at random.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module stick_direction_auto_repeat_test;
  import sdar_pkg::*;

  typedef struct packed {
    logic signed [AXIS_W-1:0] axis_x;
    logic signed [AXIS_W-1:0] axis_y;
    logic [DT_W-1:0]          delta_us;
    logic                     active;
  } tick_t;

  typedef struct packed {
    logic nav_valid;
    dir_t nav_dir;
  } nav_t;

  typedef struct packed {
    tick_t tick;
    logic  known;
    nav_t  want;
  } probe_t;

  localparam nav_t NO_EVENT = '{1'b0, DIR_UP};
  localparam int   N_PROBES = 25;

  // Rows run under the reset settings: dead zone 8192, delay 400000 us and
  // interval 100000 us. Rows with known = 0 are checked by the predictor.
  localparam probe_t PROBES [N_PROBES] = '{
    '{'{ 16'sd32767,      16'sd0,      20'd0,       1'b0}, 1'b0, NO_EVENT},
    '{'{ 16'sd0,          16'sd0,      20'd0,       1'b1}, 1'b1, NO_EVENT},
    '{'{ 16'sd8192,       16'sd0,      20'd5,       1'b1}, 1'b1, NO_EVENT},
    '{'{ 16'sd8193,       16'sd0,      20'd5,       1'b1}, 1'b1, '{1'b1, DIR_RIGHT}},
    '{'{ 16'sd32767,      16'sd0,      20'd100000,  1'b1}, 1'b0, NO_EVENT},
    '{'{ 16'sd32767,      16'sd0,      20'd300000,  1'b1}, 1'b0, NO_EVENT},
    '{'{ 16'sd32767,      16'sd0,      20'd1,       1'b1}, 1'b0, NO_EVENT},
    '{'{ 16'sd32767,      16'sd0,      20'd99999,   1'b1}, 1'b0, NO_EVENT},
    '{'{-16'sd32768,      16'sd0,      20'd0,       1'b0}, 1'b1, NO_EVENT},
    '{'{-16'sd32768,      16'sd0,      20'hFFFFF,   1'b1}, 1'b1, '{1'b1, DIR_LEFT}},
    '{'{-16'sd32768,      16'sd0,      20'hFFFFF,   1'b1}, 1'b0, NO_EVENT},
    '{'{ 16'sd0,          16'sd32767,  20'd0,       1'b1}, 1'b1, '{1'b1, DIR_UP}},
    '{'{ 16'sd0,         -16'sd32768,  20'd0,       1'b1}, 1'b1, '{1'b1, DIR_DOWN}},
    '{'{ 16'sd20000,      16'sd20000,  20'd0,       1'b1}, 1'b1, '{1'b1, DIR_UP}},
    '{'{-16'sd20000,     -16'sd20000,  20'd0,       1'b1}, 1'b1, '{1'b1, DIR_DOWN}},
    '{'{-16'sd20000,      16'sd20000,  20'd0,       1'b1}, 1'b1, '{1'b1, DIR_UP}},
    '{'{ 16'sd20000,     -16'sd20000,  20'd0,       1'b1}, 1'b1, '{1'b1, DIR_DOWN}},
    '{'{-16'sd32768,     -16'sd32767,  20'd0,       1'b1}, 1'b1, '{1'b1, DIR_LEFT}},
    '{'{ 16'sd100,       -16'sd100,    20'd0,       1'b1}, 1'b1, NO_EVENT},
    '{'{-16'sd32768,     -16'sd32768,  20'd0,       1'b1}, 1'b1, '{1'b1, DIR_DOWN}},
    '{'{ 16'sd32767,      16'sd32767,  20'd0,       1'b1}, 1'b1, '{1'b1, DIR_UP}},
    '{'{ 16'sd32767,     -16'sd32768,  20'd0,       1'b1}, 1'b1, '{1'b1, DIR_DOWN}},
    '{'{ 16'sd32767,     -16'sd32768,  20'd0,       1'b1}, 1'b0, NO_EVENT},
    '{'{ 16'sd1,          16'sd0,      20'd7,       1'b1}, 1'b1, NO_EVENT},
    // Each axis is inside the dead zone, the magnitude is not.
    '{'{ 16'sd5793,       16'sd5793,   20'd0,       1'b1}, 1'b1, '{1'b1, DIR_UP}}
  };

  logic                   clk;
  logic                   rst       = 1'b1;
  logic                   s_tvalid  = 1'b0;
  logic                   s_tready;
  logic [IN_TDATA_W-1:0]  s_tdata   = '0;
  logic                   m_tvalid;
  logic                   m_tready  = 1'b0;
  logic [OUT_TDATA_W-1:0] m_tdata;
  logic                   cfg_valid = 1'b0;
  logic                   cfg_ready;
  logic [CFG_IDX_W-1:0]   cfg_index = '0;
  logic [CFG_DATA_W-1:0]  cfg_data  = '0;

  stick_direction_auto_repeat i_dut (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  // Predictor copy of the registers and the repeat state.
  logic [DZ_W-1:0]    cf_dead_zone = 15'd8192;
  logic [TIMER_W-1:0] cf_delay     = 32'd400000;
  logic [TIMER_W-1:0] cf_interval  = 32'd100000;
  logic               st_held      = 1'b0;
  dir_t               st_dir       = DIR_UP;
  logic [TIMER_W-1:0] st_hold_us   = '0;
  logic [TIMER_W-1:0] st_repeat_us = '0;

  nav_t nav_expected [$];
  int   fail_count   = 0;
  int   result_count = 0;

  // Sender burst state, random run state and the receiver hold-off request.
  int                       burst_left   = 0;
  int                       run_left     = 0;
  logic signed [AXIS_W-1:0] run_x        = '0;
  logic signed [AXIS_W-1:0] run_y        = '0;
  bit                       holdoff_req  = 1'b0;
  int                       holdoff_left = 0;
  int unsigned              rx_cycle     = 0;

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  initial begin
    #20_000_000;
    $display("Some tests failed");
    $finish;
  end

  function automatic logic [TIMER_W-1:0] timer_add(input logic [TIMER_W-1:0] a,
                                                   input logic [DT_W-1:0] b);
    logic [TIMER_W:0] total;
    total = (TIMER_W + 1)'(a) + (TIMER_W + 1)'(b);
    return total[TIMER_W] ? '1 : total[TIMER_W-1:0];
  endfunction

  // Advances the repeat state by one accepted tick and returns its result.
  function automatic nav_t nav_predict(input tick_t t);
    nav_t   res;
    longint ax;
    longint ay;
    longint mag_sq;
    longint dz_sq;
    dir_t   d;
    res = NO_EVENT;
    if (!t.active) return res;
    ax = longint'(t.axis_x);
    ay = longint'(t.axis_y);
    if (ax < 0) ax = -ax;
    if (ay < 0) ay = -ay;
    mag_sq = ax * ax + ay * ay;
    dz_sq  = longint'(cf_dead_zone) * longint'(cf_dead_zone);
    if (mag_sq > dz_sq) begin
      if (ax > ay) d = (t.axis_x > 0) ? DIR_RIGHT : DIR_LEFT;
      else d = (t.axis_y > 0) ? DIR_UP : DIR_DOWN;
      if (!st_held || d != st_dir) begin
        st_held      = 1'b1;
        st_dir       = d;
        st_hold_us   = '0;
        st_repeat_us = '0;
        res          = '{1'b1, d};
      end else begin
        st_hold_us = timer_add(st_hold_us, t.delta_us);
        if (st_hold_us > cf_delay) begin
          st_repeat_us = timer_add(st_repeat_us, t.delta_us);
          if (st_repeat_us >= cf_interval) begin
            st_repeat_us = '0;
            res          = '{1'b1, d};
          end
        end
      end
    end else begin
      st_held    = 1'b0;
      st_hold_us = '0;
    end
    return res;
  endfunction

  function automatic logic signed [AXIS_W-1:0] axis_of(input int unsigned m, input bit neg);
    if (neg) return AXIS_W'(-int'(m));
    return (m > 32767) ? 16'sd32767 : AXIS_W'(m);
  endfunction

  function automatic logic [DT_W-1:0] pick_delta();
    int unsigned span;
    span = (cf_interval > 32'hFFFFF) ? 32'hFFFFF : cf_interval;
    if (span == 0) span = 1000;
    case ($urandom_range(0, 9))
      0:       return '0;
      1:       return '1;
      2, 3:    return DT_W'($urandom);
      default: return DT_W'($urandom_range(0, span));
    endcase
  endfunction

  // Mostly held-stick runs that get past the delay, then dead zone runs and
  // single noise ticks.
  function automatic tick_t next_tick();
    tick_t       t;
    int unsigned major;
    int unsigned minor;
    int unsigned half;
    if (run_left == 0) begin
      case ($urandom_range(0, 9))
        0, 1, 2, 3, 4, 5: begin
          major = $urandom_range(cf_dead_zone + 1, 32768);
          minor = $urandom_range(0, major);
          case (dir_t'($urandom_range(0, 3)))
            DIR_UP: begin
              run_y = axis_of(major, 1'b0);
              run_x = axis_of(minor, $urandom_range(0, 1) != 0);
            end
            DIR_DOWN: begin
              run_y = axis_of(major, 1'b1);
              run_x = axis_of(minor, $urandom_range(0, 1) != 0);
            end
            DIR_LEFT: begin
              run_x = axis_of(major, 1'b1);
              run_y = axis_of(minor, $urandom_range(0, 1) != 0);
            end
            default: begin
              run_x = axis_of(major, 1'b0);
              run_y = axis_of(minor, $urandom_range(0, 1) != 0);
            end
          endcase
          run_left = $urandom_range(1, 40);
        end
        6: begin
          half     = cf_dead_zone / 2;
          run_x    = axis_of($urandom_range(0, half), $urandom_range(0, 1) != 0);
          run_y    = axis_of($urandom_range(0, half), $urandom_range(0, 1) != 0);
          run_left = $urandom_range(1, 6);
        end
        default: begin
          t.axis_x   = AXIS_W'($urandom);
          t.axis_y   = AXIS_W'($urandom);
          t.delta_us = pick_delta();
          t.active   = ($urandom_range(0, 3) != 0);
          return t;
        end
      endcase
    end
    run_left--;
    t.axis_x   = run_x;
    t.axis_y   = run_y;
    t.delta_us = pick_delta();
    t.active   = ($urandom_range(0, 19) != 0);
    return t;
  endfunction

  task automatic send_tick(input tick_t t, input logic known, input nav_t want);
    logic [IN_TDATA_W-1:0] word;
    nav_t                  pred;
    if (burst_left == 0) begin
      if ($urandom_range(0, 2) == 0) begin
        s_tvalid <= 1'b0;
        repeat ($urandom_range(1, 8)) @(posedge clk);
      end
      burst_left = $urandom_range(1, 30);
    end
    word = '0;
    word[X_LSB +: AXIS_W] = t.axis_x;
    word[Y_LSB +: AXIS_W] = t.axis_y;
    word[DT_LSB +: DT_W]  = t.delta_us;
    word[ACTIVE_BIT]      = t.active;
    s_tvalid <= 1'b1;
    s_tdata  <= word;
    do @(posedge clk); while (!s_tready);
    pred = nav_predict(t);
    nav_expected.push_back(known ? want : pred);
    burst_left--;
  endtask

  // Stops offering ticks until every result is back and the pipe is empty.
  task automatic settle();
    s_tvalid <= 1'b0;
    burst_left = 0;
    while (nav_expected.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic load_settings(input logic [DZ_W-1:0] dz, input logic [TIMER_W-1:0] dly,
                               input logic [TIMER_W-1:0] ivl);
    settle();
    cfg_valid <= 1'b1;
    cfg_index <= REG_DEAD_ZONE;
    cfg_data  <= CFG_DATA_W'(dz);
    do @(posedge clk); while (!cfg_ready);
    cfg_index <= REG_REPEAT_DELAY;
    cfg_data  <= dly;
    do @(posedge clk); while (!cfg_ready);
    cfg_index <= REG_REPEAT_INTERVAL;
    cfg_data  <= ivl;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    cf_dead_zone = dz;
    cf_delay     = dly;
    cf_interval  = ivl;
    run_left     = 0;
  endtask

  task automatic run_random(input int count);
    int k;
    for (k = 0; k < count; k++) begin
      if (k % 150 == 149) holdoff_req = 1'b1;
      if (k % 250 == 249) settle();
      send_tick(next_tick(), 1'b0, NO_EVENT);
    end
  endtask

  // Receiver: its own ready pattern, with long hold-offs on request.
  initial begin
    forever begin
      @(posedge clk);
      rx_cycle++;
      if (holdoff_req) begin
        holdoff_req  = 1'b0;
        holdoff_left = 80;
      end
      if (holdoff_left > 0) begin
        holdoff_left--;
        m_tready <= 1'b0;
      end else begin
        case ((rx_cycle / 97) % 4)
          0:       m_tready <= 1'b1;
          1:       m_tready <= ($urandom_range(0, 1) == 1);
          2:       m_tready <= (rx_cycle % 3 != 0);
          default: m_tready <= ($urandom_range(0, 9) != 0);
        endcase
      end
    end
  end

  always @(posedge clk) begin : result_check
    nav_t got;
    nav_t want;
    if (!rst && m_tvalid && m_tready) begin
      got.nav_valid = m_tdata[0];
      got.nav_dir   = m_tdata[2:1];
      if (nav_expected.size() == 0) begin
        fail_count++;
        if (fail_count <= 10)
          $display("result %0d arrived with no tick pending: nav_valid %0b nav_dir %0d",
                   result_count, got.nav_valid, got.nav_dir);
      end else begin
        want = nav_expected.pop_front();
        if (got.nav_valid !== want.nav_valid || got.nav_dir !== want.nav_dir) begin
          fail_count++;
          if (fail_count <= 10)
            $display("result %0d: nav_valid exp %0b got %0b, nav_dir exp %0d got %0d",
                     result_count, want.nav_valid, got.nav_valid, want.nav_dir,
                     got.nav_dir);
        end
      end
      result_count++;
    end
  end

  initial begin : stimulus
    int i;
    repeat (12) @(posedge clk);
    rst <= 1'b0;

    for (i = 0; i < N_PROBES; i++)
      send_tick(PROBES[i].tick, PROBES[i].known, PROBES[i].want);
    run_random(300);

    // Zero dead zone, delay and interval: a held tick repeats once its hold time is above zero.
    load_settings('0, '0, '0);
    run_random(250);

    load_settings('1, '1, '1);
    run_random(200);

    load_settings(DZ_W'($urandom_range(0, 32767)), $urandom_range(0, 1500000),
                  $urandom_range(0, 500000));
    holdoff_req = 1'b1;
    run_random(400);

    load_settings(DZ_W'($urandom_range(0, 16000)), $urandom_range(0, 300000),
                  $urandom_range(0, 100000));
    run_random(400);

    settle();
    if (fail_count == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

@@ sim.f @@
+incdir+hdl
hdl/sdar_pkg.sv
hdl/stick_direction_auto_repeat.sv
hdl/sdar_checker.sv
tb/sv/stick_direction_auto_repeat_test.sv
